// ===== sv/sfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Shared types and constants: register indexes, reset values, item codes and
// the controller state type.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int MAX_OUT = 32;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_EOM_FIRST  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EOM_SECOND = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PING_IN    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PING_OUT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DATA_CODE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_HANDLER_EN = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_TICK_PER   = 3'd6;

  localparam logic [7:0]  RST_EOM_FIRST  = 8'd13;
  localparam logic [7:0]  RST_EOM_SECOND = 8'd10;
  localparam logic [7:0]  RST_PING_IN    = 8'd1;
  localparam logic [7:0]  RST_PING_OUT   = 8'd2;
  localparam logic [7:0]  RST_DATA_CODE  = 8'd3;
  localparam logic [15:0] RST_TICK_PER   = 16'd1000;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic KIND_TX  = 1'b0;
  localparam logic KIND_MSG = 1'b1;

  typedef struct packed {
    logic [7:0]  eom_first_code;
    logic [7:0]  eom_second_code;
    logic [7:0]  ping_in_code;
    logic [7:0]  ping_out_code;
    logic [7:0]  data_code;
    logic        handler_enabled;
    logic [15:0] tick_period;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEND,
    ST_DEL_READ,
    ST_DEL_LOAD
  } ctrl_state_t;

endpackage

// ===== sv/sfr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface sfr_item_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface sfr_result_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_byte;
  logic       last;
  logic       overflow;

  modport source (output valid, output kind, output out_byte, output last,
                  output overflow, input ready);
  modport sink (input valid, input kind, input out_byte, input last,
                input overflow, output ready);
endinterface

// ===== sv/sfr_frame_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame buffer memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sfr_frame_mem #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/sfr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame controller
// Accepts bytes and ticks, fills the frame buffer, detects the end pair and
// sequences ping replies, periodic pings and frame delivery.
// ----------------------------------------------------------------------------
module sfr_ctrl #(
  parameter int FRAME_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sfr_pkg::cfg_t                  cfg,
  sfr_item_if.sink                       item,
  sfr_result_if.source                   result,
  output logic                           mem_we,
  output logic [$clog2(FRAME_DEPTH)-1:0] mem_waddr,
  output logic [7:0]                     mem_wdata,
  output logic                           mem_re,
  output logic [$clog2(FRAME_DEPTH)-1:0] mem_raddr,
  input  logic [7:0]                     mem_rdata
);
  import sfr_pkg::*;

  localparam int AW      = $clog2(FRAME_DEPTH);
  localparam int LW      = $clog2(FRAME_DEPTH + 1);
  localparam int CNT_CAP = (FRAME_DEPTH < MAX_OUT) ? FRAME_DEPTH : MAX_OUT;
  localparam logic [LW-1:0] LEN_FULL = LW'(FRAME_DEPTH);
  localparam logic [LW-1:0] CAP      = LW'(CNT_CAP);
  localparam logic [LW-1:0] ONE      = LW'(1);
  localparam logic [LW-1:0] SEND_END = LW'(2);

  ctrl_state_t state, state_next;

  logic [15:0]   tick_count;
  logic          synced;
  logic [LW-1:0] frame_len;
  logic [7:0]    cur_byte;
  logic [7:0]    header;
  logic          lost;
  logic [7:0]    send_head;
  logic [LW-1:0] seq_idx;
  logic [LW-1:0] del_cnt;
  logic          del_ovf;

  logic          out_valid;
  logic          out_kind;
  logic [7:0]    out_byte;
  logic          out_last;
  logic          out_ovf;

  logic          accept;
  logic          is_tick;
  logic          is_byte;
  logic [15:0]   tick_next;
  logic          tick_hit;
  logic          has_room;
  logic [LW-1:0] len_next;
  logic [7:0]    head_now;
  logic          eom;
  logic          lost_next;
  logic          ping_rx;
  logic          start_send;
  logic          start_del;
  logic          out_free;
  logic          load;
  logic          seq_done;
  logic [7:0]    send_byte;

  always_comb begin
    accept    = item.ready & item.valid;
    is_tick   = item.action == ACT_TICK;
    is_byte   = (item.action == ACT_BYTE) && (item.rx_byte != 8'd0);
    tick_next = tick_count + 16'd1;
    tick_hit  = tick_next == cfg.tick_period;
    has_room  = frame_len != LEN_FULL;
    len_next  = has_room ? frame_len + ONE : frame_len;
    head_now  = (frame_len == '0) ? item.rx_byte : header;
    eom       = (cur_byte == cfg.eom_first_code) &&
                (item.rx_byte == cfg.eom_second_code);
    lost_next = lost | ~has_room;
    ping_rx   = is_byte & eom & cfg.handler_enabled &
                (head_now == cfg.ping_in_code);
    start_send = accept & ((is_tick & tick_hit & ~synced) | ping_rx);
    start_del  = accept & is_byte & eom & cfg.handler_enabled &
                 (head_now != cfg.ping_in_code) & (head_now == cfg.data_code);
    out_free  = ~out_valid | result.ready;
    seq_done  = (state == ST_SEND) ? (seq_idx == SEND_END) : (seq_idx == del_cnt - ONE);
    case (seq_idx[1:0])
      2'd0:    send_byte = send_head;
      2'd1:    send_byte = cfg.eom_first_code;
      default: send_byte = cfg.eom_second_code;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_send) begin
          state_next = ST_SEND;
        end else if (start_del) begin
          state_next = ST_DEL_READ;
        end
      end
      ST_SEND: begin
        if (out_free && seq_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_DEL_READ: begin
        state_next = ST_DEL_LOAD;
      end
      ST_DEL_LOAD: begin
        if (out_free) begin
          state_next = seq_done ? ST_IDLE : ST_DEL_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    item.ready = state == ST_IDLE;
    load       = out_free && ((state == ST_SEND) || (state == ST_DEL_LOAD));
    mem_re     = state == ST_DEL_READ;
    mem_raddr  = seq_idx[AW-1:0];
    mem_we     = accept & is_byte & has_room;
    mem_waddr  = frame_len[AW-1:0];
    mem_wdata  = item.rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      synced     <= 1'b0;
      frame_len  <= '0;
      cur_byte   <= '0;
      lost       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && is_tick) begin
        tick_count <= tick_hit ? 16'd0 : tick_next;
      end
      if (accept && is_byte) begin
        cur_byte <= item.rx_byte;
        if (eom) begin
          frame_len <= '0;
          lost      <= 1'b0;
        end else begin
          frame_len <= len_next;
          lost      <= lost_next;
        end
      end
      if (accept && ping_rx) begin
        synced <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_byte && frame_len == '0) begin
      header <= item.rx_byte;
    end
    if (start_send) begin
      send_head <= is_tick ? cfg.ping_in_code : cfg.ping_out_code;
      seq_idx   <= '0;
    end else if (start_del) begin
      seq_idx <= '0;
      del_cnt <= (len_next > CAP) ? CAP : len_next;
      del_ovf <= lost_next | (len_next > CAP);
    end else if (load) begin
      seq_idx <= seq_idx + ONE;
    end
    if (load) begin
      out_last <= seq_done;
      if (state == ST_SEND) begin
        out_kind <= KIND_TX;
        out_byte <= send_byte;
        out_ovf  <= 1'b0;
      end else begin
        out_kind <= KIND_MSG;
        out_byte <= mem_rdata;
        out_ovf  <= del_ovf;
      end
    end
  end

  assign result.valid    = out_valid;
  assign result.kind     = out_kind;
  assign result.out_byte = out_byte;
  assign result.last     = out_last;
  assign result.overflow = out_ovf;

endmodule

// ===== sv/serial_frame_receiver_with_ping.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver with ping
// Top level: configuration registers, frame buffer memory and controller.
// ----------------------------------------------------------------------------
// A tick, a zero byte or a byte that completes no acted-on frame is accepted
// in idle and leaves the block idle. A ping frame (sent on a matching ping-in
// frame or every tick_period ticks while not in sync) occupies the block while
// its three bytes go out, plus any stall on the result channel. Each byte of
// a data frame is read from the frame buffer memory (registered read data)
// and then loaded onto the result channel. No new transaction is accepted
// while a frame is sent or delivered. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module serial_frame_receiver_with_ping #(
  parameter int FRAME_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  sfr_item_if.sink                          item,
  sfr_result_if.source                      result,
  input  logic                              cfg_we,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sfr_pkg::*;

  localparam int AW = $clog2(FRAME_DEPTH);

  cfg_t cfg;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.eom_first_code  <= RST_EOM_FIRST;
      cfg.eom_second_code <= RST_EOM_SECOND;
      cfg.ping_in_code    <= RST_PING_IN;
      cfg.ping_out_code   <= RST_PING_OUT;
      cfg.data_code       <= RST_DATA_CODE;
      cfg.handler_enabled <= 1'b0;
      cfg.tick_period     <= RST_TICK_PER;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EOM_FIRST:  cfg.eom_first_code  <= cfg_data[7:0];
        CFG_EOM_SECOND: cfg.eom_second_code <= cfg_data[7:0];
        CFG_PING_IN:    cfg.ping_in_code    <= cfg_data[7:0];
        CFG_PING_OUT:   cfg.ping_out_code   <= cfg_data[7:0];
        CFG_DATA_CODE:  cfg.data_code       <= cfg_data[7:0];
        CFG_HANDLER_EN: cfg.handler_enabled <= cfg_data[0];
        CFG_TICK_PER:   cfg.tick_period     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  sfr_frame_mem #(
    .DEPTH (FRAME_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sfr_ctrl #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule
